FILE: src/led_strip_pixel_frame_driver_macros.svh
// ----------------------------------------------------------------------------
// LED strip frame driver assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef LED_STRIP_PIXEL_FRAME_DRIVER_MACROS_SVH
`define LED_STRIP_PIXEL_FRAME_DRIVER_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define LSPFD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define LSPFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/lspfd_pkg.sv
// ----------------------------------------------------------------------------
// LED strip frame driver package
// Request codes, sequencer states, output codes and color packing functions.
// ----------------------------------------------------------------------------
`default_nettype none

package lspfd_pkg;

  typedef enum logic [1:0] {
    REQ_RGB   = 2'd0,
    REQ_WHEEL = 2'd1,
    REQ_SHOW  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_LATCH = 2'd1,
    ST_PIX   = 2'd2
  } frame_state_t;

  localparam logic [1:0]  BC_LATCH  = 2'd1;
  localparam logic [1:0]  BC_PIXEL  = 2'd3;
  localparam logic [23:0] OFF_WORD  = 24'h808080;
  localparam logic [23:0] LATCH_WORD = 24'h000000;
  localparam logic [7:0]  KEEP_BIT  = 8'h80;

  function automatic logic [23:0] pack_grb(input logic [6:0] r, input logic [6:0] g,
                                           input logic [6:0] b);
    pack_grb = {KEEP_BIT | {1'b0, g}, KEEP_BIT | {1'b0, r}, KEEP_BIT | {1'b0, b}};
  endfunction

  function automatic logic [23:0] wheel_word(input logic [8:0] pos);
    logic [6:0] step;
    logic [6:0] r;
    logic [6:0] g;
    logic [6:0] b;
    step = pos[6:0];
    r = '0;
    g = '0;
    b = '0;
    case (pos[8:7])
      2'd0: begin
        r = ~step;
        g = step;
      end
      2'd1: begin
        g = ~step;
        b = step;
      end
      2'd2: begin
        b = ~step;
        r = step;
      end
      default: begin
        r = '0;
      end
    endcase
    wheel_word = pack_grb(r, g, b);
  endfunction

endpackage

`default_nettype wire

FILE: src/led_strip_pixel_frame_driver.sv
// An accepted pixel write is registered into the store. A show or clear request enters
// ST_LATCH, which loads the latch item into the output register; then one pixel item
// follows per cycle unless the output stalls. Throughput: writes at one item per cycle;
// a show or clear request stalls the input until its last pixel item is loaded, paced
// by the single read port of the store. Reset clears the pixel store at once through
// per-entry valid bits (unwritten pixels read as zero) and sets the pixel count to 32.
// ----------------------------------------------------------------------------
// LED strip pixel frame driver
// Pixel store for a 7-bit RGB strip that streams latch and pixel items per frame.
// ----------------------------------------------------------------------------
`default_nettype none
`include "led_strip_pixel_frame_driver_macros.svh"

module led_strip_pixel_frame_driver #(
  parameter int MAX_PIXELS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // pixel_index, red, green, blue, wheel_pos, zero pad
  input  wire logic [1:0]  s_tuser,   // req_type
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // frame_word
  output logic [1:0]       m_tuser,   // byte_count
  output logic             m_tlast,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import lspfd_pkg::*;

  localparam int CAP   = (MAX_PIXELS < 63) ? MAX_PIXELS : 63;
  localparam int DEPTH = CAP;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [5:0] CAP6 = 6'(CAP);

  logic [23:0] mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [DEPTH-1:0] off;

  logic [5:0] num_pixels;
  logic [5:0] ncount;
  frame_state_t state;
  frame_state_t state_next;
  logic [5:0] pos;
  logic [5:0] pos_next;

  logic        out_valid;
  logic        out_pix;
  logic        out_off;
  logic        out_vld;
  logic        out_last;
  logic [23:0] rd_data;

  logic        s_accept;
  logic        advance;
  logic        rd_en;
  logic        load_latch;
  logic        mem_we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic [23:0] wdata;
  req_type_t   req;
  logic [4:0]  pixel_index;
  logic [6:0]  red;
  logic [6:0]  green;
  logic [6:0]  blue;
  logic [8:0]  wheel_pos;

  assign pixel_index = s_tdata[4:0];
  assign red         = s_tdata[11:5];
  assign green       = s_tdata[18:12];
  assign blue        = s_tdata[25:19];
  assign wheel_pos   = s_tdata[34:26];
  assign req         = req_type_t'(s_tuser);

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {26'd0, num_pixels} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_pixels <= 6'd32;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      num_pixels <= pwdata[5:0];
    end
  end

  assign ncount   = (num_pixels > CAP6) ? CAP6 : num_pixels;
  assign s_tready = (state == ST_IDLE);
  assign s_accept = s_tvalid && s_tready;
  assign advance  = !out_valid || m_tready;

  assign waddr  = AW'(pixel_index);
  assign raddr  = AW'(pos);
  assign wdata  = (req == REQ_RGB) ? pack_grb(red, green, blue) : wheel_word(wheel_pos);
  assign mem_we = s_accept && (req == REQ_RGB || req == REQ_WHEEL)
                  && ({1'b0, pixel_index} < ncount);

  always_comb begin
    state_next = state;
    pos_next   = pos;
    case (state)
      ST_IDLE: begin
        if (s_accept && (req == REQ_SHOW || req == REQ_CLEAR)) begin
          state_next = ST_LATCH;
        end
      end
      ST_LATCH: begin
        if (advance) begin
          pos_next   = '0;
          state_next = (ncount == 6'd0) ? ST_IDLE : ST_PIX;
        end
      end
      ST_PIX: begin
        if (advance) begin
          pos_next   = pos + 6'd1;
          state_next = (pos_next == ncount) ? ST_IDLE : ST_PIX;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    rd_en      = 1'b0;
    load_latch = 1'b0;
    case (state)
      ST_LATCH: load_latch = advance;
      ST_PIX:   rd_en      = advance;
      default:  rd_en      = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pos   <= '0;
    end else begin
      state <= state_next;
      pos   <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      off   <= '0;
    end else if (mem_we) begin
      valid[waddr] <= 1'b1;
      off[waddr]   <= 1'b0;
    end else if (s_accept && req == REQ_CLEAR) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (6'(i) < ncount) begin
          off[i] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_latch || rd_en) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_latch) begin
      out_pix  <= 1'b0;
      out_off  <= 1'b0;
      out_vld  <= 1'b0;
      out_last <= (ncount == 6'd0);
    end else if (rd_en) begin
      out_pix  <= 1'b1;
      out_off  <= off[raddr];
      out_vld  <= valid[raddr];
      out_last <= (pos_next == ncount);
    end
  end

  assign m_tvalid = out_valid;
  assign m_tlast  = out_last;
  assign m_tuser  = out_pix ? BC_PIXEL : BC_LATCH;
  assign m_tdata  = !out_pix ? LATCH_WORD :
                    out_off  ? OFF_WORD   :
                    out_vld  ? rd_data    : 24'd0;

  `LSPFD_ASSERT_SAME(a_pos_in_range, clk, rst, state == ST_PIX, pos < ncount, "frame position beyond pixel count")
  `LSPFD_ASSERT_NEXT(a_clear_marks, clk, rst, s_accept && req == REQ_CLEAR && ncount != 6'd0, off[0], "clear did not mark first pixel off")
  `LSPFD_ASSERT_NEXT(a_hold_read, clk, rst, out_valid && !m_tready, $stable(rd_data) && $stable(out_last), "stalled output word changed")

endmodule

`default_nettype wire
